// ===== rtl/nvs_pkg.sv =====
package nvs_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int DIM         = 64;
  localparam int EB          = 16;

  localparam int POS_W  = $clog2(DIM);
  localparam int ENT_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W   = 32;
  localparam int NORM_W = 38;
  localparam int A_W    = 2 * NORM_W;
  localparam int P_W    = 3 * NORM_W;
  localparam int PROD_W = 2 * (EB + 1);
  localparam int ACC_W  = 41;
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_EUC   = 2'd2,
    OP_COS   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MATCH = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_ELEM,
    K_CLEAR,
    K_ADD,
    K_EUC,
    K_COS
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [POS_W-1:0]      pos;
    logic signed [EB-1:0]  value;
    logic [ID_W-1:0]       id;
  } beat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PASS,
    B_EVAL,
    B_DECIDE,
    B_MGO,
    B_MWAIT,
    B_CMP,
    B_NEXT
  } back_state_t;

endpackage

// ===== rtl/nvs_front.sv =====
module nvs_front import nvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 full,
  input  logic [1:0]           opcode,
  input  logic signed [EB-1:0] element_value,
  input  logic                 last_element,
  input  logic [ID_W-1:0]      entry_id,
  output logic                 push,
  output beat_t                beat
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             complete;

  assign push = start && !full;

  always_comb begin
    complete   = last_element || (pos == POS_W'(DIM - 1));
    beat.pos   = pos;
    beat.value = element_value;
    beat.id    = entry_id;
    pos_next   = pos;
    case (op_t'(opcode))
      OP_CLEAR: beat.kind = K_CLEAR;
      OP_ADD:   beat.kind = complete ? K_ADD : K_ELEM;
      OP_EUC:   beat.kind = complete ? K_EUC : K_ELEM;
      default:  beat.kind = complete ? K_COS : K_ELEM;
    endcase
    if (push) begin
      if (op_t'(opcode) == OP_CLEAR || complete) pos_next = '0;
      else pos_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pos <= '0;
    else pos <= pos_next;
  end

endmodule

// ===== rtl/nvs_queue.sv =====
module nvs_queue import nvs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  beat_t din,
  input  logic  pop,
  output beat_t head,
  output logic  full,
  output logic  empty
);

  beat_t           slots [QDEPTH];
  logic [QA_W-1:0] wp;
  logic [QA_W-1:0] rp;
  logic [QA_W:0]   fill;

  assign full  = (fill == (QA_W+1)'(QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/nvs_mul.sv =====
module nvs_mul import nvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [A_W-1:0]    a,
  input  logic [NORM_W-1:0] b,
  output logic              done,
  output logic [P_W-1:0]    p
);

  localparam int MCNT_W = $clog2(NORM_W + 1);

  logic [P_W-1:0]    ma;
  logic [NORM_W-1:0] mb;
  logic [MCNT_W-1:0] cnt;
  logic              run;

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        p   <= '0;
        ma  <= P_W'(a);
        mb  <= b;
        cnt <= MCNT_W'(NORM_W);
        run <= 1'b1;
      end else if (run) begin
        if (mb[0]) p <= p + ma;
        ma  <= ma << 1;
        mb  <= mb >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == MCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/nvs_back.sv =====
module nvs_back import nvs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  beat_t            hd,
  output logic             pop,
  output logic             result_strobe,
  output logic [1:0]       status,
  output logic [ID_W-1:0]  match_id,
  output logic [CNT_W-1:0] entry_count
);

  back_state_t state, state_next;

  logic signed [EB-1:0] qbuf     [DIM];
  logic signed [EB-1:0] vec_mem  [MAX_ENTRIES*DIM];
  logic [ID_W-1:0]      id_mem   [MAX_ENTRIES];
  logic [NORM_W-1:0]    norm_mem [MAX_ENTRIES];

  logic signed [EB-1:0] q_rd, v_rd;
  logic [ID_W-1:0]      id_rd;
  logic [NORM_W-1:0]    nm_rd;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  e;
  logic [POS_W:0]    idx;
  logic [POS_W-1:0]  qlast, s1idx;
  kind_t             opk;
  logic [ID_W-1:0]   id_in;
  logic              qpass;
  logic              s1v, s2v;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, best_s;
  logic [NORM_W-1:0] qn, cm, bm, bn;
  logic signed [1:0] cs, bs;
  logic              have;
  logic [ID_W-1:0]   best_id;
  logic [P_W-1:0]    lp, rp;
  logic [1:0]        mstep;
  status_t           status_r;

  logic              issuing, pass_end, take, last_entry, fin_add;
  logic signed [EB-1:0] qm;
  logic signed [EB:0]   qm17, v17, d17, pa, pb;
  logic signed [ACC_W-1:0] acc_mag;
  logic              zero_n;
  logic [NORM_W-1:0] eval_m;
  logic signed [1:0] eval_s;
  logic              mul_go, mul_done;
  logic [A_W-1:0]    mul_a;
  logic [NORM_W-1:0] mul_b;
  logic [P_W-1:0]    mul_p;

  nvs_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  assign status      = status_r;
  assign pop         = (state == B_IDLE) && !empty;
  assign issuing     = (state == B_PASS) && (idx < (POS_W+1)'(DIM));
  assign pass_end    = (state == B_PASS) && !issuing && !s1v && !s2v;
  assign fin_add     = pass_end && (opk == K_ADD);
  assign last_entry  = (e + 1'b1) >= count;
  assign mul_go      = (state == B_MGO);

  always_comb begin
    qm   = (s1idx <= qlast) ? q_rd : '0;
    qm17 = {qm[EB-1], qm};
    v17  = {v_rd[EB-1], v_rd};
    d17  = qm17 - v17;
    if (qpass) begin
      pa = qm17;
      pb = qm17;
    end else if (opk == K_EUC) begin
      pa = d17;
      pb = d17;
    end else begin
      pa = qm17;
      pb = v17;
    end
    zero_n  = (qn == '0) || (nm_rd == '0);
    acc_mag = acc[ACC_W-1] ? -acc : acc;
    eval_m  = zero_n ? '0 : acc_mag[NORM_W-1:0];
    if (zero_n || acc == '0) eval_s = 2'sd0;
    else if (acc[ACC_W-1])   eval_s = -2'sd1;
    else                     eval_s = 2'sd1;
  end

  // operands for L = m*m*(bn or 1) and R = (bm*bm or qn)*en
  always_comb begin
    case (mstep)
      2'd0: begin
        mul_a = A_W'(cm);
        mul_b = cm;
      end
      2'd1: begin
        mul_a = lp[A_W-1:0];
        mul_b = have ? bn : NORM_W'(1);
      end
      2'd2: begin
        mul_a = A_W'(have ? bm : qn);
        mul_b = have ? bm : NORM_W'(1);
      end
      default: begin
        mul_a = rp[A_W-1:0];
        mul_b = nm_rd;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    take       = 1'b0;
    case (state)
      B_IDLE: begin
        if (pop) begin
          case (hd.kind)
            K_ADD:         if (count < CNT_W'(MAX_ENTRIES)) state_next = B_PASS;
            K_EUC, K_COS:  if (count != '0) state_next = B_PASS;
            default:       state_next = B_IDLE;
          endcase
        end
      end
      B_PASS: begin
        if (pass_end) begin
          if (opk == K_ADD)  state_next = B_IDLE;
          else if (!qpass)   state_next = B_EVAL;
        end
      end
      B_EVAL: begin
        if (opk == K_EUC) begin
          take       = !have || (acc < best_s);
          state_next = B_NEXT;
        end else begin
          state_next = B_DECIDE;
        end
      end
      B_DECIDE: begin
        if ((!have && cs < 0) || (have && cs == bs && cs != 0)) begin
          state_next = B_MGO;
        end else begin
          take       = have ? (cs > bs) : 1'b1;
          state_next = B_NEXT;
        end
      end
      B_MGO:   state_next = B_MWAIT;
      B_MWAIT: if (mul_done) state_next = (mstep == 2'd3) ? B_CMP : B_MGO;
      B_CMP: begin
        // antiparallel entries never become the first pick
        if (!have)       take = (lp != rp);
        else if (cs > 0) take = (lp > rp);
        else             take = (lp < rp);
        state_next = B_NEXT;
      end
      B_NEXT:  state_next = last_entry ? B_IDLE : B_PASS;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (pop && hd.kind != K_CLEAR) qbuf[hd.pos] <= hd.value;
    q_rd <= qbuf[idx[POS_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s1v && qpass && opk == K_ADD) vec_mem[{count[ENT_W-1:0], s1idx}] <= qm;
    v_rd <= vec_mem[{e[ENT_W-1:0], idx[POS_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (fin_add) begin
      id_mem[count[ENT_W-1:0]]   <= id_in;
      norm_mem[count[ENT_W-1:0]] <= acc[NORM_W-1:0];
    end
    id_rd <= id_mem[e[ENT_W-1:0]];
    nm_rd <= norm_mem[e[ENT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      result_strobe <= 1'b0;
      s1v           <= 1'b0;
      s2v           <= 1'b0;
    end else begin
      result_strobe <= 1'b0;

      // element pipeline: read, multiply, accumulate
      s1v   <= issuing;
      s1idx <= idx[POS_W-1:0];
      s2v   <= s1v;
      if (issuing) idx <= idx + 1'b1;
      if (s1v) prod <= pa * pb;
      if (s2v) acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

      if (take) begin
        have    <= 1'b1;
        bs      <= cs;
        bm      <= cm;
        bn      <= nm_rd;
        best_s  <= acc;
        best_id <= id_rd;
      end

      case (state)
        B_IDLE: begin
          if (pop) begin
            opk   <= hd.kind;
            id_in <= hd.id;
            qlast <= hd.pos;
            qpass <= (hd.kind != K_EUC);
            have  <= 1'b0;
            e     <= '0;
            idx   <= '0;
            acc   <= '0;
            entry_count <= count;
            match_id    <= '0;
            case (hd.kind)
              K_CLEAR: begin
                count         <= '0;
                entry_count   <= '0;
                status_r      <= ST_OK;
                result_strobe <= 1'b1;
              end
              K_ADD: begin
                if (count >= CNT_W'(MAX_ENTRIES)) begin
                  status_r      <= ST_FULL;
                  result_strobe <= 1'b1;
                end
              end
              K_EUC, K_COS: begin
                if (count == '0) begin
                  status_r      <= ST_NONE;
                  result_strobe <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        B_PASS: begin
          if (pass_end) begin
            if (opk == K_ADD) begin
              count         <= count + 1'b1;
              entry_count   <= count + 1'b1;
              status_r      <= ST_OK;
              result_strobe <= 1'b1;
            end else if (qpass) begin
              qn    <= acc[NORM_W-1:0];
              qpass <= 1'b0;
              idx   <= '0;
              acc   <= '0;
            end
          end
        end
        B_EVAL: begin
          cs <= eval_s;
          cm <= eval_m;
        end
        B_DECIDE: mstep <= 2'd0;
        B_MWAIT: begin
          if (mul_done) begin
            if (mstep < 2'd2) lp <= mul_p;
            else rp <= mul_p;
            mstep <= mstep + 1'b1;
          end
        end
        B_NEXT: begin
          if (last_entry) begin
            status_r      <= have ? ST_MATCH : ST_NONE;
            match_id      <= have ? best_id : '0;
            result_strobe <= 1'b1;
          end else begin
            e   <= e + 1'b1;
            idx <= '0;
            acc <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/nearest_vector_search.sv =====
// Element beats are taken one per cycle through a 4-beat queue; busy rises only when it fills.
// Add: the result follows one pass over the query buffer, which stores the vector in the table.
// Euclidean search: one pass per stored entry, one element per cycle from the vector RAM.
// Cosine search: a query-norm pass, then a pass per entry; an entry whose sign ties the best
// so far (or a negative one with no pick yet) also waits on up to four serial multiplier products.
// Reset (rst, synchronous) empties the table at once; results cannot be stalled.
module nearest_vector_search import nvs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           opcode,
  input  logic signed [EB-1:0] element_value,
  input  logic                 last_element,
  input  logic [ID_W-1:0]      entry_id,
  output logic                 result_strobe,
  output logic [1:0]           status,
  output logic [ID_W-1:0]      match_id,
  output logic [CNT_W-1:0]     entry_count
);

  logic  push, pop, full, empty;
  beat_t beat_in, head;

  assign busy = full;

  nvs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .full          (full),
    .opcode        (opcode),
    .element_value (element_value),
    .last_element  (last_element),
    .entry_id      (entry_id),
    .push          (push),
    .beat          (beat_in)
  );

  nvs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (beat_in),
    .pop   (pop),
    .head  (head),
    .full  (full),
    .empty (empty)
  );

  nvs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .hd            (head),
    .pop           (pop),
    .result_strobe (result_strobe),
    .status        (status),
    .match_id      (match_id),
    .entry_count   (entry_count)
  );

endmodule

// ===== rtl/nvs_checker.sv =====
module nvs_checker import nvs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             result_strobe,
  input logic [1:0]       status,
  input logic [ID_W-1:0]  match_id,
  input logic [CNT_W-1:0] entry_count
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !result_strobe)
    else $error("result strobe right after reset");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && status == ST_FULL) |-> entry_count == CNT_W'(MAX_ENTRIES))
    else $error("full reported below capacity");

  a_match_nonempty: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && status == ST_MATCH) |-> entry_count != '0)
    else $error("match from empty table");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && status != ST_MATCH) |-> match_id == '0)
    else $error("id set without match");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count over capacity");

endmodule

bind nearest_vector_search nvs_checker u_nvs_checker (
  .clk           (clk),
  .rst           (rst),
  .result_strobe (result_strobe),
  .status        (status),
  .match_id      (match_id),
  .entry_count   (entry_count)
);
